[design/lbpg_pkg.sv]
// shared types, codes and timing constants for the led and buzzer annunciator
`timescale 1ns / 1ps
`default_nettype none
package lbpg_pkg;

  localparam int COUNT_BITS = 16;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

  // func codes
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_UPDATE = 2'd1;
  localparam logic [1:0] FUNC_MODE   = 2'd2;

  // system modes
  localparam logic [2:0] MODE_READY   = 3'd0;
  localparam logic [2:0] MODE_NORMAL  = 3'd1;
  localparam logic [2:0] MODE_WARNING = 3'd2;
  localparam logic [2:0] MODE_OK      = 3'd3;
  localparam logic [2:0] MODE_KEY     = 3'd4;

  // millisecond thresholds
  localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] T_50     = COUNT_BITS'(50);
  localparam logic [COUNT_BITS-1:0] T_100    = COUNT_BITS'(100);
  localparam logic [COUNT_BITS-1:0] T_150    = COUNT_BITS'(150);
  localparam logic [COUNT_BITS-1:0] T_200    = COUNT_BITS'(200);
  localparam logic [COUNT_BITS-1:0] T_250    = COUNT_BITS'(250);
  localparam logic [COUNT_BITS-1:0] T_300    = COUNT_BITS'(300);
  localparam logic [COUNT_BITS-1:0] T_400    = COUNT_BITS'(400);
  localparam logic [COUNT_BITS-1:0] T_500    = COUNT_BITS'(500);
  localparam logic [COUNT_BITS-1:0] T_600    = COUNT_BITS'(600);
  localparam logic [COUNT_BITS-1:0] T_800    = COUNT_BITS'(800);
  localparam logic [COUNT_BITS-1:0] T_1000   = COUNT_BITS'(1000);
  localparam logic [COUNT_BITS-1:0] T_3000   = COUNT_BITS'(3000);

  typedef struct packed {
    logic [2:0]            mode;
    logic [COUNT_BITS-1:0] beep;
    logic [COUNT_BITS-1:0] light;
    logic                  buzzer;
    logic                  led_one;
    logic                  led_two;
  } state_t;

endpackage
`default_nettype wire

[design/lbpg_step.sv]
// next-state logic for one word: tick, pattern update or mode write
`timescale 1ns / 1ps
`default_nettype none
module lbpg_step (
  input  wire logic [1:0]      func,
  input  wire logic [2:0]      new_mode,
  input  wire lbpg_pkg::state_t cur,
  output lbpg_pkg::state_t     nxt
);

  always_comb begin
    nxt = cur;
    case (func)
      lbpg_pkg::FUNC_TICK: begin
        if (cur.beep != lbpg_pkg::CNT_MAX) begin
          nxt.beep = cur.beep + lbpg_pkg::CNT_ONE;
        end
        if (cur.light != lbpg_pkg::CNT_MAX) begin
          nxt.light = cur.light + lbpg_pkg::CNT_ONE;
        end
      end
      lbpg_pkg::FUNC_UPDATE: begin
        // led pattern
        if (cur.mode == lbpg_pkg::MODE_WARNING) begin
          if (cur.light < lbpg_pkg::T_200) begin
            nxt.led_one = 1'b1;
            nxt.led_two = 1'b0;
          end else if (cur.light < lbpg_pkg::T_400) begin
            nxt.led_one = 1'b0;
            nxt.led_two = 1'b1;
          end
          if (cur.light > lbpg_pkg::T_400) begin
            nxt.light = '0;
          end
        end else if (cur.mode == lbpg_pkg::MODE_OK) begin
          // on in even 50 ms slots
          if (cur.light < lbpg_pkg::T_300) begin
            nxt.led_one = (cur.light < lbpg_pkg::T_50) ||
                          (cur.light >= lbpg_pkg::T_100 && cur.light < lbpg_pkg::T_150) ||
                          (cur.light >= lbpg_pkg::T_200 && cur.light < lbpg_pkg::T_250);
          end
          if (cur.light > lbpg_pkg::T_300) begin
            nxt.light = '0;
          end
        end else begin
          if (cur.light < lbpg_pkg::T_200) begin
            nxt.led_one = 1'b1;
            nxt.led_two = 1'b0;
          end else if (cur.light < lbpg_pkg::T_3000) begin
            nxt.led_one = 1'b0;
            nxt.led_two = 1'b0;
          end
          if (cur.light > lbpg_pkg::T_3000) begin
            nxt.light = '0;
          end
        end
        // buzzer pattern
        if (cur.mode inside {lbpg_pkg::MODE_READY, lbpg_pkg::MODE_OK}) begin
          // on in even 100 ms slots
          if (cur.beep < lbpg_pkg::T_600) begin
            nxt.buzzer = (cur.beep < lbpg_pkg::T_100) ||
                         (cur.beep >= lbpg_pkg::T_200 && cur.beep < lbpg_pkg::T_300) ||
                         (cur.beep >= lbpg_pkg::T_400 && cur.beep < lbpg_pkg::T_500);
          end
          if (cur.beep > lbpg_pkg::T_600) begin
            nxt.mode = lbpg_pkg::MODE_NORMAL;
          end
        end else if (cur.mode == lbpg_pkg::MODE_WARNING) begin
          if (cur.beep < lbpg_pkg::T_800) begin
            nxt.buzzer = 1'b1;
          end else if (cur.beep < lbpg_pkg::T_1000) begin
            nxt.buzzer = 1'b0;
          end
          if (cur.beep > lbpg_pkg::T_1000) begin
            nxt.mode = lbpg_pkg::MODE_NORMAL;
          end
        end else if (cur.mode == lbpg_pkg::MODE_KEY) begin
          if (cur.beep < lbpg_pkg::T_50) begin
            nxt.buzzer = 1'b1;
          end else if (cur.beep < lbpg_pkg::T_100) begin
            nxt.buzzer = 1'b0;
          end
          if (cur.beep > lbpg_pkg::T_100) begin
            nxt.mode = lbpg_pkg::MODE_NORMAL;
          end
        end else begin
          nxt.buzzer = 1'b0;
          nxt.beep   = '0;
        end
      end
      lbpg_pkg::FUNC_MODE: begin
        if (new_mode <= lbpg_pkg::MODE_KEY) begin
          nxt.mode = new_mode;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[design/led_buzzer_pattern_generator.sv]
// top level of the led and buzzer annunciator
// usage:
//   in channel: one word per event, func in bits 1:0 (tick, pattern update,
//   mode write), new_mode in bits 4:2 (used by mode writes only)
//   out channel: one word for every input word, giving the buzzer and led
//   drive levels and the system mode after that event
//   a result is registered and presented in the cycle after its word is accepted
//   throughput: one word per cycle while the receiver takes each result; the
//   single next-state stage and the result register set this figure
//   a result waiting in the output register does not block the input as long
//   as the receiver takes it in the same cycle; if the receiver stalls,
//   in_tready drops until the held result is taken
//   reset: synchronous, active low; mode returns to normal, both millisecond
//   counters clear, buzzer and leds off, output register empty
`timescale 1ns / 1ps
`default_nettype none
module led_buzzer_pattern_generator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [lbpg_pkg::IN_DATA_W-1:0]  in_tdata,   // func[1:0], new_mode[4:2]
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [lbpg_pkg::OUT_DATA_W-1:0]      out_tdata   // buzzer_on, led_one_on, led_two_on, mode_now[5:3]
);

  lbpg_pkg::state_t                  state_r;
  lbpg_pkg::state_t                  state_nxt;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [lbpg_pkg::OUT_DATA_W-1:0]   out_data_r;
  logic [lbpg_pkg::OUT_DATA_W-1:0]   out_data_nxt;
  logic                              in_accept;

  lbpg_step u_step (
    .func     (in_tdata[1:0]),
    .new_mode (in_tdata[4:2]),
    .cur      (state_r),
    .nxt      (state_nxt)
  );

  assign in_tready  = !out_valid_r || out_tready;
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {2'b00, state_nxt.mode, state_nxt.led_two,
                       state_nxt.led_one, state_nxt.buzzer};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode    <= lbpg_pkg::MODE_NORMAL;
      state_r.beep    <= '0;
      state_r.light   <= '0;
      state_r.buzzer  <= 1'b0;
      state_r.led_one <= 1'b0;
      state_r.led_two <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r <= state_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // mode register only ever holds a defined mode
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r.mode <= lbpg_pkg::MODE_KEY)
    else $error("system mode out of range");

  // every accepted word yields a result next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted word produced no result");

  // a valid mode write shows up in the result
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tdata[1:0] == lbpg_pkg::FUNC_MODE &&
     in_tdata[4:2] <= lbpg_pkg::MODE_KEY)
    |=> out_data_r[5:3] == $past(in_tdata[4:2]))
    else $error("mode write not reflected");

  // the beep counter saturates and never wraps on a tick
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tdata[1:0] == lbpg_pkg::FUNC_TICK &&
     state_r.beep == lbpg_pkg::CNT_MAX)
    |=> state_r.beep == lbpg_pkg::CNT_MAX)
    else $error("beep counter wrapped");
`endif

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// self-checking testbench for the led and buzzer annunciator
`timescale 1ns / 1ps
module tb_top;
  import lbpg_pkg::*;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [2:0] mode;
    logic       led_two;
    logic       led_one;
    logic       buzzer;
  } drive_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // func[1:0], new_mode[4:2]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // buzzer_on, led_one_on, led_two_on, mode_now[5:3]

  state_t ann;
  drive_t expected_drive_q[$];
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     fail_count = 0;
  int     items_sent = 0;
  int     cycle_count = 0;

  led_buzzer_pattern_generator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** led_buzzer_pattern_generator: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // next drive levels and mode after one event
  function automatic drive_t annunciate(input logic [1:0] func, input logic [2:0] mode_field);
    logic [2:0]            m;
    logic [COUNT_BITS-1:0] slot;
    drive_t                r;
    case (func)
      FUNC_TICK: begin
        if (ann.beep != CNT_MAX) ann.beep = ann.beep + CNT_ONE;
        if (ann.light != CNT_MAX) ann.light = ann.light + CNT_ONE;
      end
      FUNC_UPDATE: begin
        m = ann.mode;
        if (m == MODE_WARNING) begin
          if (ann.light < T_200) begin
            ann.led_one = 1'b1;
            ann.led_two = 1'b0;
          end else if (ann.light < T_400) begin
            ann.led_one = 1'b0;
            ann.led_two = 1'b1;
          end
          if (ann.light > T_400) ann.light = '0;
        end else if (m == MODE_OK) begin
          if (ann.light < T_300) begin
            slot = ann.light / T_50;
            ann.led_one = ~slot[0];
          end
          if (ann.light > T_300) ann.light = '0;
        end else begin
          if (ann.light < T_200) begin
            ann.led_one = 1'b1;
            ann.led_two = 1'b0;
          end else if (ann.light < T_3000) begin
            ann.led_one = 1'b0;
            ann.led_two = 1'b0;
          end
          if (ann.light > T_3000) ann.light = '0;
        end
        if (m == MODE_READY || m == MODE_OK) begin
          if (ann.beep < T_600) begin
            slot = ann.beep / T_100;
            ann.buzzer = ~slot[0];
          end
          if (ann.beep > T_600) ann.mode = MODE_NORMAL;
        end else if (m == MODE_WARNING) begin
          if (ann.beep < T_800) ann.buzzer = 1'b1;
          else if (ann.beep < T_1000) ann.buzzer = 1'b0;
          if (ann.beep > T_1000) ann.mode = MODE_NORMAL;
        end else if (m == MODE_KEY) begin
          if (ann.beep < T_50) ann.buzzer = 1'b1;
          else if (ann.beep < T_100) ann.buzzer = 1'b0;
          if (ann.beep > T_100) ann.mode = MODE_NORMAL;
        end else begin
          ann.buzzer = 1'b0;
          ann.beep = '0;
        end
      end
      FUNC_MODE: begin
        if (mode_field <= MODE_KEY) ann.mode = mode_field;
      end
      default: ;
    endcase
    r.buzzer  = ann.buzzer;
    r.led_one = ann.led_one;
    r.led_two = ann.led_two;
    r.mode    = ann.mode;
    return r;
  endfunction

  always @(negedge clk) begin
    drive_t want;
    drive_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = drive_t'(out_tdata[5:0]);
      if (expected_drive_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result word %h at %0t", out_tdata, $realtime);
      end else begin
        want = expected_drive_q.pop_front();
        if (got.buzzer !== want.buzzer || got.led_one !== want.led_one ||
            got.led_two !== want.led_two || got.mode !== want.mode) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"mismatch at %0t: expected buzzer %0b led1 %0b led2 %0b mode %0d,",
                      " got buzzer %0b led1 %0b led2 %0b mode %0d"},
                     $realtime, want.buzzer, want.led_one, want.led_two, want.mode,
                     got.buzzer, got.led_one, got.led_two, got.mode);
        end
      end
    end
  end

  task automatic send_word(input logic [1:0] func, input logic [2:0] mode_field);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, mode_field, func};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    expected_drive_q.push_back(annunciate(func, mode_field));
    items_sent++;
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_drive_q.size() != 0);
  endtask

  task automatic tick_until(input bit on_beep, input int target);
    while (int'(on_beep ? ann.beep : ann.light) != target)
      send_word(FUNC_TICK, 3'($urandom_range(7)));
  endtask

  // update one before, at and one past the end of a window
  task automatic probe_edge(input bit on_beep, input int last);
    tick_until(on_beep, last - 1);
    send_word(FUNC_UPDATE, 3'($urandom_range(7)));
    repeat (2) begin
      send_word(FUNC_TICK, 3'($urandom_range(7)));
      send_word(FUNC_UPDATE, 3'($urandom_range(7)));
    end
  endtask

  task automatic back_to_normal();
    send_word(FUNC_MODE, MODE_NORMAL);
    send_word(FUNC_UPDATE, 3'($urandom_range(7)));
  endtask

  task automatic test_event_kinds();
    send_word(FUNC_UPDATE, 3'd7);
    send_word(FUNC_TICK, 3'd5);
    send_word(FUNC_SPARE, 3'd6);
    for (int b = MODE_KEY + 1; b < 8; b++) send_word(FUNC_MODE, 3'(b));
    send_word(FUNC_UPDATE, 3'd0);
    send_word(FUNC_MODE, MODE_READY);
    send_word(FUNC_UPDATE, 3'd3);
    send_word(FUNC_MODE, MODE_WARNING);
    send_word(FUNC_UPDATE, 3'd1);
    send_word(FUNC_MODE, MODE_OK);
    send_word(FUNC_UPDATE, 3'd4);
    send_word(FUNC_MODE, MODE_KEY);
    send_word(FUNC_UPDATE, 3'd2);
    send_word(FUNC_SPARE, 3'd1);
    back_to_normal();
  endtask

  task automatic test_window_edges();
    send_word(FUNC_MODE, MODE_OK);
    probe_edge(1'b0, int'(T_300));
    back_to_normal();
    send_word(FUNC_MODE, MODE_WARNING);
    probe_edge(1'b0, int'(T_400));
    back_to_normal();
    send_word(FUNC_MODE, MODE_KEY);
    probe_edge(1'b1, int'(T_100));
    back_to_normal();
  endtask

  task automatic test_random_patterns(input int budget);
    int         start;
    int         pick;
    int         steps;
    int         ticks;
    logic [2:0] target;
    start = items_sent;
    while (items_sent - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        send_word(2'($urandom_range(3)), 3'($urandom_range(7)));
      end else begin
        if (pick < 20) target = 3'($urandom_range(MODE_KEY + 1, 7));
        else if (pick < 32) target = MODE_WARNING;
        else if (pick < 40) target = MODE_NORMAL;
        else begin
          case ($urandom_range(2))
            0: target = MODE_READY;
            1: target = MODE_OK;
            default: target = MODE_KEY;
          endcase
        end
        if ($urandom_range(1)) back_to_normal();
        send_word(FUNC_MODE, target);
        steps = $urandom_range(8, 150);
        while (steps > 0) begin
          ticks = ($urandom_range(9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 6);
          repeat (ticks) send_word(FUNC_TICK, 3'($urandom_range(7)));
          send_word(FUNC_UPDATE, 3'($urandom_range(7)));
          if (ann.mode == MODE_NORMAL || $urandom_range(49) == 0) steps = 0;
          else steps--;
        end
      end
    end
  endtask

  initial begin
    ann = '0;
    ann.mode = MODE_NORMAL;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 15;
    recv_idle_pct = 56;
    test_event_kinds();
    test_window_edges();
    test_random_patterns(250);
    hold_until_drained();

    send_idle_pct = 56;
    recv_idle_pct = 15;
    test_random_patterns(250);
    hold_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_patterns(250);

    hold_until_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_drive_q.size() == 0) begin
      $display("** led_buzzer_pattern_generator: PASSED **");
    end else begin
      $display("** led_buzzer_pattern_generator: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
design/lbpg_pkg.sv
design/lbpg_step.sv
design/led_buzzer_pattern_generator.sv
tb/sv/tb_top.sv
